[design/cdss_pkg.sv]
// ----------------------------------------------------------------------------
// cdss_pkg
// Types, command codes and constants shared by the countdown timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cdss_pkg;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_STOP = 3'd1,
    CMD_RUN  = 3'd2,
    CMD_SHOW = 3'd3,
    CMD_HIDE = 3'd4,
    CMD_SET  = 3'd5
  } cmd_e;

  localparam logic [19:0] COUNT_RESET   = 20'd359999;
  localparam logic [12:0] CENTI_PER_MIN = 13'd6000;
  localparam logic [6:0]  CENTI_PER_SEC = 7'd100;
  localparam logic [5:0]  MIN_CLAMP     = 6'd60;

  // floor(x / 6000) = (x * MIN_RECIP) >> MIN_SHIFT, exact for x < 2^22
  localparam logic [20:0] MIN_RECIP = 21'd1431656;
  localparam int unsigned MIN_SHIFT = 33;
  // floor(x / 100) = (x * SEC_RECIP) >> SEC_SHIFT, exact for x < 43690
  localparam logic [12:0] SEC_RECIP = 13'd5243;
  localparam int unsigned SEC_SHIFT = 19;

  // timer state after one item
  typedef struct packed {
    logic [19:0] count;
    logic        run;
    logic        disp;
  } snap_t;

  // split results handed to the display stage
  typedef struct packed {
    logic [7:0]  min_raw;
    logic [12:0] rem;
    logic [5:0]  sec;
    logic        run;
    logic        disp;
  } split_t;

  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] t;
    t = 7'(tens_of(v)) * 7'd10;
    return 4'(v - t);
  endfunction

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[design/cdss_if.sv]
// ----------------------------------------------------------------------------
// cdss_if
// Valid/ready channels for timer commands and display results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdss_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [6:0] set_minutes;
  logic [6:0] set_seconds;
  logic [6:0] set_hundredths;

  modport source (output valid, cmd, set_minutes, set_seconds, set_hundredths,
                  input ready);
  modport sink   (input valid, cmd, set_minutes, set_seconds, set_hundredths,
                  output ready);
endinterface

interface cdss_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  minutes_shown;
  logic [5:0]  seconds_shown;
  logic [6:0]  hundredths_shown;
  logic [31:0] seg_low;
  logic [15:0] seg_high;
  logic        running;

  modport source (output valid, minutes_shown, seconds_shown, hundredths_shown,
                  seg_low, seg_high, running, input ready);
  modport sink   (input valid, minutes_shown, seconds_shown, hundredths_shown,
                  seg_low, seg_high, running, output ready);
endinterface

`default_nettype wire

[design/cdss_ctrl.sv]
// ----------------------------------------------------------------------------
// cdss_ctrl
// Timer state (count, run flag, display flag) and command decode.
// ----------------------------------------------------------------------------
`default_nettype none

module cdss_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  cdss_in_if.sink            in_i,
  output cdss_pkg::snap_t    snap_o,
  output logic               valid_o,
  input  wire logic          ready_i
);

  cdss_pkg::cmd_e  cmd;
  cdss_pkg::snap_t state_q, state_d;
  cdss_pkg::snap_t snap_q;
  logic            valid_q;
  logic            accept;
  logic [19:0]     set_val;

  assign cmd        = cdss_pkg::cmd_e'(in_i.cmd);
  assign in_i.ready = !valid_q || ready_i;
  assign accept     = in_i.valid && in_i.ready;

  assign set_val = 20'(in_i.set_minutes) * 20'(cdss_pkg::CENTI_PER_MIN)
                 + 20'(in_i.set_seconds) * 20'(cdss_pkg::CENTI_PER_SEC)
                 + 20'(in_i.set_hundredths);

  always_comb begin
    state_d = state_q;
    unique case (cmd)
      cdss_pkg::CMD_TICK: begin
        if (state_q.run) begin
          if (state_q.count != 20'd0) begin
            state_d.count = state_q.count - 20'd1;
          end else begin
            state_d.run = 1'b0;
          end
        end
      end
      cdss_pkg::CMD_STOP: state_d.run   = 1'b0;
      cdss_pkg::CMD_RUN:  state_d.run   = 1'b1;
      cdss_pkg::CMD_SHOW: state_d.disp  = 1'b1;
      cdss_pkg::CMD_HIDE: state_d.disp  = 1'b0;
      cdss_pkg::CMD_SET:  state_d.count = set_val;
      default:            state_d       = state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.count <= cdss_pkg::COUNT_RESET;
      state_q.run   <= 1'b1;
      state_q.disp  <= 1'b1;
      valid_q       <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (in_i.ready) begin
        valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      snap_q <= state_d;
    end
  end

  assign snap_o  = snap_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

[design/cdss_split.sv]
// ----------------------------------------------------------------------------
// cdss_split
// Three-stage split of the count into whole minutes, remainder and seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module cdss_split (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cdss_pkg::snap_t snap_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  output cdss_pkg::split_t   split_o,
  output logic               valid_o,
  input  wire logic          ready_i
);

  // stage a: minutes by reciprocal multiply
  logic [40:0] prod_a;
  logic [19:0] cnt_a_q;
  logic [7:0]  min_a_q;
  logic        run_a_q, disp_a_q;
  logic        va_q, rdy_a;

  // stage b: remainder after whole minutes
  logic [19:0] rem_b;
  logic [12:0] rem_b_q;
  logic [7:0]  min_b_q;
  logic        run_b_q, disp_b_q;
  logic        vb_q, rdy_b;

  // stage c: seconds by reciprocal multiply
  logic [25:0]      prod_c;
  cdss_pkg::split_t res_c_q;
  logic             vc_q, rdy_c;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  assign prod_a = 41'(snap_i.count) * 41'(cdss_pkg::MIN_RECIP);
  assign rem_b  = cnt_a_q - 20'(min_a_q) * 20'(cdss_pkg::CENTI_PER_MIN);
  assign prod_c = 26'(rem_b_q) * 26'(cdss_pkg::SEC_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      cnt_a_q  <= snap_i.count;
      min_a_q  <= prod_a[cdss_pkg::MIN_SHIFT +: 8];
      run_a_q  <= snap_i.run;
      disp_a_q <= snap_i.disp;
    end
    if (rdy_b && va_q) begin
      rem_b_q  <= rem_b[12:0];
      min_b_q  <= min_a_q;
      run_b_q  <= run_a_q;
      disp_b_q <= disp_a_q;
    end
    if (rdy_c && vb_q) begin
      res_c_q.min_raw <= min_b_q;
      res_c_q.rem     <= rem_b_q;
      res_c_q.sec     <= prod_c[cdss_pkg::SEC_SHIFT +: 6];
      res_c_q.run     <= run_b_q;
      res_c_q.disp    <= disp_b_q;
    end
  end

  assign split_o = res_c_q;
  assign valid_o = vc_q;

endmodule

`default_nettype wire

[design/cdss_seg.sv]
// ----------------------------------------------------------------------------
// cdss_seg
// Hundredths, minute clamp, digit split, segment encode and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdss_seg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cdss_pkg::split_t split_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  cdss_out_if.source         out_o
);

  logic [12:0] hun_full;
  logic [6:0]  hun;
  logic [5:0]  mins;
  logic [31:0] seg_lo;
  logic [15:0] seg_hi;
  logic        valid_q;

  logic [5:0]  min_q, sec_q;
  logic [6:0]  hun_q;
  logic [31:0] seg_lo_q;
  logic [15:0] seg_hi_q;
  logic        run_q;

  assign ready_o  = !valid_q || out_o.ready;
  assign hun_full = split_i.rem - 13'(split_i.sec) * 13'(cdss_pkg::CENTI_PER_SEC);
  assign hun      = hun_full[6:0];
  assign mins     = (split_i.min_raw > 8'(cdss_pkg::MIN_CLAMP)) ?
                    cdss_pkg::MIN_CLAMP : split_i.min_raw[5:0];

  always_comb begin
    seg_lo = 32'h0;
    seg_hi = 16'h0;
    if (split_i.disp) begin
      seg_hi = {cdss_pkg::seg_of(cdss_pkg::tens_of(7'(mins))),
                cdss_pkg::seg_of(cdss_pkg::ones_of(7'(mins)))};
      seg_lo = {cdss_pkg::seg_of(cdss_pkg::tens_of(7'(split_i.sec))),
                cdss_pkg::seg_of(cdss_pkg::ones_of(7'(split_i.sec))),
                cdss_pkg::seg_of(cdss_pkg::tens_of(hun)),
                cdss_pkg::seg_of(cdss_pkg::ones_of(hun))};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      min_q    <= mins;
      sec_q    <= split_i.sec;
      hun_q    <= hun;
      seg_lo_q <= seg_lo;
      seg_hi_q <= seg_hi;
      run_q    <= split_i.run;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.minutes_shown    = min_q;
  assign out_o.seconds_shown    = sec_q;
  assign out_o.hundredths_shown = hun_q;
  assign out_o.seg_low          = seg_lo_q;
  assign out_o.seg_high         = seg_hi_q;
  assign out_o.running          = run_q;

endmodule

`default_nettype wire

[design/countdown_stopwatch_seven_segment.sv]
// ----------------------------------------------------------------------------
// countdown_stopwatch_seven_segment
// Centisecond countdown timer with six seven-segment digit outputs.
//
//   channel  dir  payload
//   in_i     in   cmd, set_minutes, set_seconds, set_hundredths
//   out_o    out  minutes_shown, seconds_shown, hundredths_shown,
//                 seg_low, seg_high, running
//
// one item per cycle while the output does not stall; an accepted item
// passes the state snapshot, then the divide pipeline: minutes multiply,
// remainder, seconds multiply, then digit encode into the result register
// reset: count 359999, running, display on, pipeline empty
// a stalled output backs up stage by stage; empty stages keep accepting
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_stopwatch_seven_segment (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cdss_in_if.sink   in_i,
  cdss_out_if.source out_o
);

  cdss_pkg::snap_t  snap;
  cdss_pkg::split_t split;
  logic             snap_valid, snap_ready;
  logic             split_valid, split_ready;

  cdss_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .snap_o  (snap),
    .valid_o (snap_valid),
    .ready_i (snap_ready)
  );

  cdss_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .snap_i  (snap),
    .valid_i (snap_valid),
    .ready_o (snap_ready),
    .split_o (split),
    .valid_o (split_valid),
    .ready_i (split_ready)
  );

  cdss_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .split_i (split),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input not ready while output is ready");

  a_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.minutes_shown <= 6'd60))
    else $error("minutes above clamp");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.seconds_shown < 6'd60 && out_o.hundredths_shown < 7'd100))
    else $error("seconds or hundredths out of range");

  a_seg_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.seg_high == 16'h0) == (out_o.seg_low == 32'h0)))
    else $error("segment words disagree on blanking");
`endif

endmodule

`default_nettype wire
